[hw/rtl/header_framed_box_deframer_assert.svh]
// Assertion macros for the header framed box deframer.
`ifndef HEADER_FRAMED_BOX_DEFRAMER_ASSERT_SVH
`define HEADER_FRAMED_BOX_DEFRAMER_ASSERT_SVH
`ifndef SYNTH
// Clocked assertion, disabled while reset is held.
`define HFBD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Clocked assertion that also holds during reset.
`define HFBD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define HFBD_ASSERT(lbl, prop, msg)
`define HFBD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[hw/rtl/hfbd_pkg.sv]
// Types and constants shared by the header framed box deframer.
package hfbd_pkg;

    localparam int FRAME_MAX_BYTES = 10;
    localparam int CNT_W           = $clog2(FRAME_MAX_BYTES + 1);
    localparam int BOX_MIN_BYTES   = 5;
    localparam int TAP_DEPTH       = 5;

    typedef logic [7:0]       t_byte;
    typedef logic [CNT_W-1:0] t_count;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HDR1   = 2'd1,
        PH_DATA   = 2'd2,
        PH_CLOSED = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        CFG_FIRST_HEADER  = 2'd0,
        CFG_SECOND_HEADER = 2'd1,
        CFG_END_MARKER    = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_byte first_header;
        t_byte second_header;
        t_byte end_marker;
    } t_cfg;

    typedef struct packed {
        t_byte box_height;
        t_byte box_width;
        t_byte box_y;
        t_byte box_x;
    } t_box;

    typedef struct packed {
        t_phase phase;
        t_count count;
    } t_stat;

endpackage

[hw/rtl/hfbd_byte_if.sv]
// Valid/ready channel carrying one received byte per word.
interface hfbd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[hw/rtl/hfbd_box_if.sv]
// Valid/ready channel carrying one decoded box per word.
interface hfbd_box_if;
    logic       valid;
    logic       ready;
    logic [7:0] box_x;
    logic [7:0] box_y;
    logic [7:0] box_width;
    logic [7:0] box_height;

    modport source (output valid, output box_x, output box_y, output box_width,
                    output box_height, input ready);
    modport sink   (input valid, input box_x, input box_y, input box_width,
                    input box_height, output ready);
endinterface

[hw/rtl/header_framed_box_deframer.sv]
// Header framed box deframer: one received byte per word in, one box per frame out.
// A box appears on the output in the cycle after the confirming byte is accepted.
// Throughput: one byte per cycle; input stalls only while a frame is closed and the
// previous box still waits on the output.
// Reset: synchronous active-low; registers return to 0x2C, 0x12, 0x5B, parser to idle,
// output empty. No clearing pass is needed.
module header_framed_box_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    hfbd_byte_if.sink  i_rx,
    hfbd_box_if.source o_box
);
    import hfbd_pkg::*;

`include "header_framed_box_deframer_assert.svh"

    t_cfg  r_cfg;
    logic  r_out_valid, n_out_valid;
    t_box  r_out_box;
    logic  in_acc;
    logic  emit;
    t_box  box;
    t_stat stat;

    // Configuration registers; writes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_header  <= 8'h2C;
            r_cfg.second_header <= 8'h12;
            r_cfg.end_marker    <= 8'h5B;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FIRST_HEADER:  r_cfg.first_header  <= i_cfg_data;
                CFG_SECOND_HEADER: r_cfg.second_header <= i_cfg_data;
                CFG_END_MARKER:    r_cfg.end_marker    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Only the confirming byte can produce a box, so hold the input only when
    // the frame is closed and the output slot is still occupied.
    assign i_rx.ready = !((stat.phase == PH_CLOSED) && r_out_valid && !o_box.ready);
    assign in_acc     = i_rx.valid && i_rx.ready;

    hfbd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (in_acc),
        .i_byte  (i_rx.rx_byte),
        .i_cfg   (r_cfg),
        .o_emit  (emit),
        .o_box   (box),
        .o_stat  (stat)
    );

    // Output register: load on emit, drop once taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (o_box.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_box <= box;
        end
    end

    assign o_box.valid      = r_out_valid;
    assign o_box.box_x      = r_out_box.box_x;
    assign o_box.box_y      = r_out_box.box_y;
    assign o_box.box_width  = r_out_box.box_width;
    assign o_box.box_height = r_out_box.box_height;

    `HFBD_ASSERT(a_rise_after_confirm, $rose(r_out_valid) |-> $past(in_acc && (stat.phase == PH_CLOSED)), "box appeared without a confirming byte")
    `HFBD_ASSERT(a_closed_has_box, (stat.phase == PH_CLOSED) |-> (stat.count >= t_count'(BOX_MIN_BYTES)), "frame closed with too few bytes")
    `HFBD_ASSERT(a_idle_empty, (stat.phase == PH_IDLE) |-> (stat.count == '0), "idle parser holds bytes")

endmodule

[hw/rtl/hfbd_parser.sv]
// Frame parser: phase machine, byte count and the last five stored bytes.
module hfbd_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_acc,
    input  logic [7:0]    i_byte,
    input  hfbd_pkg::t_cfg  i_cfg,
    output logic          o_emit,
    output hfbd_pkg::t_box  o_box,
    output hfbd_pkg::t_stat o_stat
);
    import hfbd_pkg::*;

    t_phase r_phase, n_phase;
    t_count r_count, n_count;
    t_byte  r_tap [TAP_DEPTH];
    logic   shift_en;
    t_count cnt_inc;
    logic   close_frame;
    logic   frame_short;

    assign cnt_inc     = r_count + t_count'(1);
    assign close_frame = (cnt_inc >= t_count'(FRAME_MAX_BYTES)) || (i_byte == i_cfg.end_marker);
    assign frame_short = cnt_inc < t_count'(BOX_MIN_BYTES);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (i_acc) begin
            unique case (r_phase)
                PH_IDLE:   n_phase = (i_byte == i_cfg.first_header) ? PH_HDR1 : PH_IDLE;
                PH_HDR1:   n_phase = (i_byte == i_cfg.second_header) ? PH_DATA : PH_IDLE;
                PH_DATA: begin
                    if (close_frame) begin
                        n_phase = frame_short ? PH_IDLE : PH_CLOSED;
                    end
                end
                PH_CLOSED: n_phase = PH_IDLE;
                default:   n_phase = PH_IDLE;
            endcase
        end
    end

    // Count, store and emit.
    always_comb begin
        n_count  = r_count;
        shift_en = 1'b0;
        o_emit   = 1'b0;
        if (i_acc) begin
            unique case (r_phase)
                PH_IDLE: begin
                    shift_en = (i_byte == i_cfg.first_header);
                    n_count  = shift_en ? cnt_inc : '0;
                end
                PH_HDR1: begin
                    shift_en = (i_byte == i_cfg.second_header);
                    n_count  = shift_en ? cnt_inc : '0;
                end
                PH_DATA: begin
                    shift_en = 1'b1;
                    n_count  = (close_frame && frame_short) ? '0 : cnt_inc;
                end
                PH_CLOSED: begin
                    // Tap 0 holds the last stored byte of the closed frame.
                    o_emit  = (r_tap[0] == i_cfg.end_marker);
                    n_count = '0;
                end
                default: n_count = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // Newest byte in tap 0; older ones move up.
    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            r_tap[0] <= i_byte;
            for (int i = 1; i < TAP_DEPTH; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    assign o_box.box_x      = r_tap[4];
    assign o_box.box_y      = r_tap[3];
    assign o_box.box_width  = r_tap[2];
    assign o_box.box_height = r_tap[1];

    assign o_stat.phase = r_phase;
    assign o_stat.count = r_count;

endmodule

[sim/header_framed_box_deframer_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the header framed box deframer: directed frames, random traffic.
module header_framed_box_deframer_tb;
    import hfbd_pkg::*;

    localparam int HALF_PERIOD      = 10;
    localparam int RESET_CYCLES     = 9;
    localparam int SETTLE_CYCLES    = 4;    // the output box is registered after the confirming byte
    localparam int WATCHDOG_LIMIT   = 5000; // cycles without any accepted word
    localparam int RANDOM_ITEMS     = 780;
    localparam int RANDOM_SETTINGS  = 6;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int MAX_REPORTS      = 10;

    typedef enum int {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_PATTERN
    } t_sink_mode;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    hfbd_byte_if rx_if();
    hfbd_box_if  box_if();

    header_framed_box_deframer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx       (rx_if),
        .o_box      (box_if)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Parser shadow: registers, phase, byte store and the latched box,
    // advanced once per accepted byte word.
    // ------------------------------------------------------------------
    t_cfg        model_cfg;
    t_phase      model_phase;
    int unsigned model_count;
    t_byte       model_store [FRAME_MAX_BYTES];
    t_box        model_latched;
    t_box        expected_boxes [$];

    // Stimulus and sink control
    int          burst_left;
    bit          sender_gaps;
    int          items_sent;
    int          hold_request;
    int          hold_left;
    t_sink_mode  sink_mode;
    int unsigned sink_tick;
    int          mismatch_count;
    int          idle_cycles;

    // Return the parser to idle; the store keeps its bytes after a good frame.
    function automatic void drop_frame(bit clear_store);
        model_phase = PH_IDLE;
        model_count = 0;
        if (clear_store) begin
            foreach (model_store[i]) model_store[i] = '0;
        end
    endfunction

    function automatic void store_byte(t_byte b);
        if (model_count < FRAME_MAX_BYTES) begin
            model_store[model_count] = b;
            model_count++;
        end
    endfunction

    // Advance the shadow parser by one byte; queue the box a confirmed frame yields.
    function automatic void decode_byte(t_byte b);
        int unsigned n;
        case (model_phase)
            PH_IDLE: begin
                if (b == model_cfg.first_header) begin
                    store_byte(b);
                    model_phase = PH_HDR1;
                end else begin
                    drop_frame(1'b1);
                end
            end
            PH_HDR1: begin
                if (b == model_cfg.second_header) begin
                    store_byte(b);
                    model_phase = PH_DATA;
                end else begin
                    drop_frame(1'b1);
                end
            end
            PH_DATA: begin
                store_byte(b);
                if (model_count >= FRAME_MAX_BYTES || b == model_cfg.end_marker) begin
                    // A marker before five stored bytes is an error, not a frame.
                    if (model_count < BOX_MIN_BYTES) begin
                        drop_frame(1'b1);
                    end else begin
                        n = model_count;
                        model_latched.box_x      = model_store[n-5];
                        model_latched.box_y      = model_store[n-4];
                        model_latched.box_width  = model_store[n-3];
                        model_latched.box_height = model_store[n-2];
                        model_phase = PH_CLOSED;
                    end
                end
            end
            default: begin
                // Compare against the marker value in force right now.
                if (model_count >= 1 && model_store[model_count-1] == model_cfg.end_marker) begin
                    expected_boxes.push_back(model_latched);
                    drop_frame(1'b0);
                end else begin
                    drop_frame(1'b1);
                end
            end
        endcase
    endfunction

    function automatic void report_box(string what, t_box want, t_box got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("box %s: expected x=%02h y=%02h w=%02h h=%02h, got x=%02h y=%02h w=%02h h=%02h",
                     what, want.box_x, want.box_y, want.box_width, want.box_height,
                     got.box_x, got.box_y, got.box_width, got.box_height);
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample both channels and the register port at each edge.
    // Check the output word first; a byte accepted on this edge can only
    // produce a box on a later edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_box got;
        t_box want;
        if (!i_rst_n) begin
            model_cfg.first_header  = 8'h2C;
            model_cfg.second_header = 8'h12;
            model_cfg.end_marker    = 8'h5B;
            model_latched           = '0;
            expected_boxes.delete();
            drop_frame(1'b1);
        end else begin
            if (box_if.valid && box_if.ready) begin
                got.box_x      = box_if.box_x;
                got.box_y      = box_if.box_y;
                got.box_width  = box_if.box_width;
                got.box_height = box_if.box_height;
                if (expected_boxes.size() == 0) begin
                    report_box("unexpected", '0, got);
                end else begin
                    want = expected_boxes.pop_front();
                    if (got.box_x !== want.box_x || got.box_y !== want.box_y ||
                        got.box_width !== want.box_width ||
                        got.box_height !== want.box_height) begin
                        report_box("mismatch", want, got);
                    end
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_FIRST_HEADER:  model_cfg.first_header  = i_cfg_data;
                    CFG_SECOND_HEADER: model_cfg.second_header = i_cfg_data;
                    CFG_END_MARKER:    model_cfg.end_marker    = i_cfg_data;
                    default: ;
                endcase
            end
            if (rx_if.valid && rx_if.ready) decode_byte(rx_if.rx_byte);
        end
    end

    // Receiver: honor a long hold-off request first, else stall per the current mode.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            box_if.ready <= 1'b0;
        end else begin
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            sink_tick++;
            if (hold_left != 0) begin
                hold_left--;
                box_if.ready <= 1'b0;
            end else begin
                case (sink_mode)
                    SINK_ALWAYS: box_if.ready <= 1'b1;
                    SINK_RANDOM: box_if.ready <= ($urandom_range(0, 99) < 60);
                    default:     box_if.ready <= (sink_tick % 7) > 2;
                endcase
            end
        end
    end

    // Watchdog: end the run if no word moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (rx_if.valid && rx_if.ready) ||
            (box_if.valid && box_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender: offer one byte word, idling between bursts when gaps are on.
    // Return on the edge at which the word is accepted, valid still high.
    // ------------------------------------------------------------------
    task automatic send_byte(input t_byte b);
        int gap;
        if (burst_left == 0) begin
            gap        = sender_gaps ? $urandom_range(0, 8) : 0;
            burst_left = $urandom_range(1, 12);
            if (gap != 0) begin
                rx_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        items_sent++;
    endtask

    // Drop valid, drain the expected boxes, then let the pipeline go quiet.
    task automatic settle();
        rx_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (expected_boxes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers, and the unused index when asked; call only when idle.
    task automatic write_config(input t_cfg c, input bit poke_unused);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FIRST_HEADER;
        i_cfg_data <= c.first_header;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SECOND_HEADER;
        i_cfg_data <= c.second_header;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_END_MARKER;
        i_cfg_data <= c.end_marker;
        @(posedge i_clk);
        if (poke_unused) begin
            i_cfg_idx  <= CFG_UNUSED;
            i_cfg_data <= t_byte'($urandom_range(0, 255));
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_byte data_byte();
        t_byte b;
        do b = t_byte'($urandom_range(0, 255)); while (b == model_cfg.end_marker);
        return b;
    endfunction

    // Send a well-formed frame (sometimes filling the store), a broken one, or noise.
    task automatic send_random_frame(input bit well_formed_only);
        int unsigned pick;
        int unsigned n_data;
        bit          fill_store;
        pick = well_formed_only ? 0 : $urandom_range(0, 99);
        if (pick < 70) begin
            fill_store = ($urandom_range(0, 7) == 0);
            n_data     = fill_store ? FRAME_MAX_BYTES - 2 : $urandom_range(2, FRAME_MAX_BYTES - 3);
            send_byte(model_cfg.first_header);
            send_byte(model_cfg.second_header);
            repeat (n_data) send_byte(data_byte());
            if (!fill_store) send_byte(model_cfg.end_marker);
            send_byte(t_byte'($urandom_range(0, 255)));
        end else if (pick < 85) begin
            send_byte(model_cfg.first_header);
            if ($urandom_range(0, 1)) begin
                send_byte(t_byte'($urandom_range(0, 255)));
            end else begin
                // Marker too early: at most four stored bytes.
                send_byte(model_cfg.second_header);
                repeat ($urandom_range(0, 1)) send_byte(data_byte());
                send_byte(model_cfg.end_marker);
            end
        end else begin
            repeat ($urandom_range(1, 4)) send_byte(t_byte'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Directed tests, with the reset register values unless a test writes its own
    // ------------------------------------------------------------------
    task automatic test_default_frame();
        // Four stored bytes before the marker: box is headers plus two data bytes.
        send_byte(8'h2C);
        send_byte(8'h12);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5B);
        send_byte(8'h77);
        settle();
    endtask

    task automatic test_unexpected_bytes();
        send_byte(8'h00);
        send_byte(8'h2C);
        send_byte(8'h00);
        settle();
    endtask

    task automatic test_early_terminator();
        send_byte(8'h2C);
        send_byte(8'h12);
        send_byte(8'h01);
        send_byte(8'h5B);
        settle();
    endtask

    task automatic test_full_store();
        // Store fills without a marker; the confirming byte gives a reception error.
        send_byte(8'h2C);
        send_byte(8'h12);
        for (int i = 1; i <= FRAME_MAX_BYTES - 2; i++) send_byte(t_byte'(i));
        send_byte(8'h5B);
        settle();
    endtask

    task automatic test_register_change_mid_frame();
        t_cfg c;
        c.first_header  = 8'h2C;
        c.second_header = 8'h12;
        c.end_marker    = 8'h5B;
        send_byte(8'h2C);
        send_byte(8'h12);
        send_byte(8'hAA);
        send_byte(8'hBB);
        send_byte(8'hCC);
        settle();
        // Move the marker onto the next data byte: it now closes the frame.
        c.end_marker = 8'hDD;
        write_config(c, 1'b0);
        send_byte(8'hDD);
        settle();
        // Restore the marker before confirming: the stored last byte no longer matches.
        c.end_marker = 8'h5B;
        write_config(c, 1'b0);
        send_byte(8'h00);
        settle();
    endtask

    // ------------------------------------------------------------------
    // Random traffic over several register settings, extremes included
    // ------------------------------------------------------------------
    task automatic test_random_frames();
        t_cfg  settings [RANDOM_SETTINGS];
        t_byte v;
        int    target;
        settings[0] = '{8'h2C, 8'h12, 8'h5B};
        settings[1] = '{8'h00, 8'h00, 8'h00};
        settings[2] = '{8'hFF, 8'hFF, 8'hFF};
        settings[3] = '{t_byte'($urandom_range(0, 255)), t_byte'($urandom_range(0, 255)),
                        t_byte'($urandom_range(0, 255))};
        settings[4] = '{8'h00, 8'hFF, 8'h80};
        v = t_byte'($urandom_range(0, 255));
        settings[5] = '{v, t_byte'($urandom_range(0, 255)), v};
        for (int s = 0; s < RANDOM_SETTINGS; s++) begin
            write_config(settings[s], s == 3);
            sink_mode   = t_sink_mode'(s % 3);
            sender_gaps = (s % 2 == 0);
            target      = items_sent + RANDOM_ITEMS / RANDOM_SETTINGS;
            while (items_sent < target) send_random_frame(1'b0);
            settle();
        end
    endtask

    // Hold the output off for a long stretch while frames keep coming, so the input stalls.
    task automatic test_output_backpressure();
        sink_mode    = SINK_ALWAYS;
        sender_gaps  = 1'b0;
        hold_request = LONG_HOLD_CYCLES;
        repeat (30) send_random_frame(1'b1);
        settle();
        sink_mode   = SINK_RANDOM;
        sender_gaps = 1'b1;
        repeat (20) send_random_frame(1'b1);
        settle();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_FIRST_HEADER;
        i_cfg_data    <= '0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        burst_left     = 0;
        sender_gaps    = 1'b1;
        items_sent     = 0;
        hold_request   = 0;
        hold_left      = 0;
        sink_mode      = SINK_PATTERN;
        sink_tick      = 0;
        mismatch_count = 0;
        idle_cycles    = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_frame();
        test_unexpected_bytes();
        test_early_terminator();
        test_full_store();
        test_register_change_mid_frame();
        test_random_frames();
        test_output_backpressure();

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[header_framed_box_deframer.f]
+incdir+hw/rtl
hw/rtl/hfbd_pkg.sv
hw/rtl/hfbd_byte_if.sv
hw/rtl/hfbd_box_if.sv
hw/rtl/hfbd_parser.sv
hw/rtl/header_framed_box_deframer.sv
sim/header_framed_box_deframer_tb.sv
